>>> rtl/ufst_pkg.sv
// ufst_pkg: shared types, constants and the microprogram of the union-find edge stage
// no dependencies; used by every module of the block but ufst_ram, by scoped names
package ufst_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int NODE_W        = 8;
    localparam int WEIGHT_W      = 16;
    localparam int TOTAL_W       = 32;
    localparam int COUNT_W       = 9;
    localparam int RANK_W        = 4;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 9'd256;
    localparam logic [RANK_W-1:0]  RANK_MAX       = 4'd15;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t ST_CLEAR     = 4'd0;
    localparam step_t ST_CLEAR_END = 4'd1;
    localparam step_t ST_EMIT      = 4'd2;
    localparam step_t ST_IDLE      = 4'd3;
    localparam step_t ST_DISPATCH  = 4'd4;
    localparam step_t ST_LOAD_A0   = 4'd5;
    localparam step_t ST_CHASE_A   = 4'd6;
    localparam step_t ST_LOAD_A1   = 4'd7;
    localparam step_t ST_COMP_A    = 4'd8;
    localparam step_t ST_LOAD_B0   = 4'd9;
    localparam step_t ST_CHASE_B   = 4'd10;
    localparam step_t ST_LOAD_B1   = 4'd11;
    localparam step_t ST_COMP_B    = 4'd12;
    localparam step_t ST_UNION     = 4'd13;
    localparam step_t ST_RANK_UP   = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR_WR,
        OP_EMIT,
        OP_ACCEPT,
        OP_LOAD_A,
        OP_CHASE_A,
        OP_COMP_A,
        OP_LOAD_B,
        OP_CHASE_B,
        OP_COMP_B,
        OP_UNION,
        OP_RANK_UP
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_MORE,
        C_NO_ITEM,
        C_OUT_BUSY,
        C_NO_REQ,
        C_CLEAR,
        C_BAD,
        C_NOT_ROOT,
        C_NE_ROOT_A,
        C_NE_ROOT_B,
        C_SAME_ROOT
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic clr_more;
        logic no_item;
        logic out_busy;
        logic no_req;
        logic is_clear;
        logic is_bad;
        logic not_root;
        logic ne_root_a;
        logic ne_root_b;
        logic same_root;
    } flags_t;

    // control store: jump to target when cond holds, else step on
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            ST_CLEAR:     w = '{OP_CLEAR_WR, C_CLR_MORE,  ST_CLEAR};
            ST_CLEAR_END: w = '{OP_NOP,      C_NO_ITEM,   ST_IDLE};
            ST_EMIT:      w = '{OP_EMIT,     C_OUT_BUSY,  ST_EMIT};
            ST_IDLE:      w = '{OP_ACCEPT,   C_NO_REQ,    ST_IDLE};
            ST_DISPATCH:  w = '{OP_NOP,      C_CLEAR,     ST_CLEAR};
            ST_LOAD_A0:   w = '{OP_LOAD_A,   C_BAD,       ST_EMIT};
            ST_CHASE_A:   w = '{OP_CHASE_A,  C_NOT_ROOT,  ST_CHASE_A};
            ST_LOAD_A1:   w = '{OP_LOAD_A,   C_NEVER,     ST_IDLE};
            ST_COMP_A:    w = '{OP_COMP_A,   C_NE_ROOT_A, ST_COMP_A};
            ST_LOAD_B0:   w = '{OP_LOAD_B,   C_NEVER,     ST_IDLE};
            ST_CHASE_B:   w = '{OP_CHASE_B,  C_NOT_ROOT,  ST_CHASE_B};
            ST_LOAD_B1:   w = '{OP_LOAD_B,   C_NEVER,     ST_IDLE};
            ST_COMP_B:    w = '{OP_COMP_B,   C_NE_ROOT_B, ST_COMP_B};
            ST_UNION:     w = '{OP_UNION,    C_SAME_ROOT, ST_EMIT};
            ST_RANK_UP:   w = '{OP_RANK_UP,  C_ALWAYS,    ST_EMIT};
            default:      w = '{OP_NOP,      C_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/ufst_ram.sv
// ufst_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module ufst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ufst_seq.sv
// ufst_seq: step counter, control store lookup and conditional jump logic
// depends on ufst_pkg
module ufst_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ufst_pkg::flags_t  flags,
    output ufst_pkg::uop_t    op
);

    ufst_pkg::step_t  upc_reg;
    ufst_pkg::step_t  upc_next;
    ufst_pkg::uword_t uw;
    logic             take;

    always_comb begin
        uw = ufst_pkg::ucode(upc_reg);
        unique case (uw.cond)
            ufst_pkg::C_NEVER:     take = 1'b0;
            ufst_pkg::C_ALWAYS:    take = 1'b1;
            ufst_pkg::C_CLR_MORE:  take = flags.clr_more;
            ufst_pkg::C_NO_ITEM:   take = flags.no_item;
            ufst_pkg::C_OUT_BUSY:  take = flags.out_busy;
            ufst_pkg::C_NO_REQ:    take = flags.no_req;
            ufst_pkg::C_CLEAR:     take = flags.is_clear;
            ufst_pkg::C_BAD:       take = flags.is_bad;
            ufst_pkg::C_NOT_ROOT:  take = flags.not_root;
            ufst_pkg::C_NE_ROOT_A: take = flags.ne_root_a;
            ufst_pkg::C_NE_ROOT_B: take = flags.ne_root_b;
            ufst_pkg::C_SAME_ROOT: take = flags.same_root;
            default:               take = 1'b0;
        endcase
        upc_next = take ? uw.target : upc_reg + 1'b1;
        op       = uw.op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ufst_pkg::ST_CLEAR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/ufst_dp.sv
// ufst_dp: datapath with node store, root and rank registers, total and result register
// depends on ufst_pkg and ufst_ram
module ufst_dp #(
    parameter int MAX_NODES = ufst_pkg::MAX_NODES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ufst_pkg::uop_t                      op,
    output ufst_pkg::flags_t                    flags,
    input  logic                                cfg_wr_en,
    input  logic [ufst_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [ufst_pkg::NODE_W-1:0]         s_node_a,
    input  logic [ufst_pkg::NODE_W-1:0]         s_node_b,
    input  logic [ufst_pkg::WEIGHT_W-1:0]       s_edge_weight,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_joined,
    output logic [ufst_pkg::TOTAL_W-1:0]        m_total_weight,
    output logic                                m_bad_node
);

    localparam int PW = $clog2(MAX_NODES);
    localparam int RW = ufst_pkg::RANK_W;
    localparam int EW = PW + RW;
    localparam int CW = ($clog2(MAX_NODES + 1) > ufst_pkg::COUNT_W) ?
                        $clog2(MAX_NODES + 1) : ufst_pkg::COUNT_W;
    localparam logic [PW-1:0] LAST_NODE = PW'(MAX_NODES - 1);
    localparam logic [CW-1:0] MAX_EXT   = CW'(MAX_NODES);

    logic [ufst_pkg::COUNT_W-1:0]  node_count_reg, node_count_next;
    logic                          kind_reg, kind_next;
    logic [ufst_pkg::NODE_W-1:0]   a_reg, a_next;
    logic [ufst_pkg::NODE_W-1:0]   b_reg, b_next;
    logic [ufst_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic                          bad_reg, bad_next;
    logic                          joined_reg, joined_next;
    logic                          item_reg, item_next;
    logic [PW-1:0]                 cur_reg, cur_next;
    logic [PW-1:0]                 root_a_reg, root_a_next;
    logic [PW-1:0]                 root_b_reg, root_b_next;
    logic [RW-1:0]                 rank_a_reg, rank_a_next;
    logic [RW-1:0]                 rank_b_reg, rank_b_next;
    logic [ufst_pkg::TOTAL_W-1:0]  sum_reg, sum_next;
    logic [PW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_joined_reg, m_joined_next;
    logic                          m_bad_reg, m_bad_next;
    logic [ufst_pkg::TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [PW-1:0] rd_parent;
    logic [RW-1:0] rd_rank;
    logic [PW-1:0] a_idx;
    logic [PW-1:0] b_idx;
    logic [CW-1:0] a_ext, b_ext, nc_ext;
    logic          in_bad;
    logic          out_busy;

    // entry layout: parent above rank
    ufst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_parent = ram_rdata[EW-1:RW];
    assign rd_rank   = ram_rdata[RW-1:0];
    assign a_idx     = PW'(a_reg);
    assign b_idx     = PW'(b_reg);
    assign a_ext     = CW'(s_node_a);
    assign b_ext     = CW'(s_node_b);
    assign nc_ext    = CW'(node_count_reg);
    assign in_bad    = !s_kind && (a_ext >= nc_ext || a_ext >= MAX_EXT ||
                                   b_ext >= nc_ext || b_ext >= MAX_EXT);
    assign out_busy  = m_valid_reg && !m_ready;
    assign s_ready   = (op == ufst_pkg::OP_ACCEPT);

    assign m_valid        = m_valid_reg;
    assign m_joined       = m_joined_reg;
    assign m_bad_node     = m_bad_reg;
    assign m_total_weight = m_total_reg;

    always_comb begin
        flags.clr_more  = (clr_cnt_reg != LAST_NODE);
        flags.no_item   = !item_reg;
        flags.out_busy  = out_busy;
        flags.no_req    = !s_valid;
        flags.is_clear  = kind_reg;
        flags.is_bad    = bad_reg;
        flags.not_root  = (rd_parent != cur_reg);
        flags.ne_root_a = (cur_reg != root_a_reg);
        flags.ne_root_b = (cur_reg != root_b_reg);
        flags.same_root = (root_a_reg == root_b_reg);
    end

    always_comb begin
        node_count_next = node_count_reg;
        kind_next       = kind_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        weight_next     = weight_reg;
        bad_next        = bad_reg;
        joined_next     = joined_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        root_a_next     = root_a_reg;
        root_b_next     = root_b_reg;
        rank_a_next     = rank_a_reg;
        rank_b_next     = rank_b_reg;
        sum_next        = sum_reg;
        clr_cnt_next    = clr_cnt_reg;
        m_valid_next    = m_valid_reg;
        m_joined_next   = m_joined_reg;
        m_bad_next      = m_bad_reg;
        m_total_next    = m_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = '0;
        ram_raddr       = cur_reg;

        unique case (op)
            ufst_pkg::OP_CLEAR_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = {clr_cnt_reg, RW'(0)};
                clr_cnt_next = (clr_cnt_reg == LAST_NODE) ? '0 : clr_cnt_reg + 1'b1;
                sum_next     = '0;
            end
            ufst_pkg::OP_ACCEPT: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    a_next      = s_node_a;
                    b_next      = s_node_b;
                    weight_next = s_edge_weight;
                    bad_next    = in_bad;
                    joined_next = 1'b0;
                    item_next   = 1'b1;
                end
            end
            ufst_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    item_next = 1'b0;
                end
            end
            ufst_pkg::OP_LOAD_A: begin
                cur_next  = a_idx;
                ram_raddr = a_idx;
            end
            ufst_pkg::OP_LOAD_B: begin
                cur_next  = b_idx;
                ram_raddr = b_idx;
            end
            ufst_pkg::OP_CHASE_A: begin
                root_a_next = cur_reg;
                rank_a_next = rd_rank;
                if (rd_parent != cur_reg) begin
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ufst_pkg::OP_CHASE_B: begin
                root_b_next = cur_reg;
                rank_b_next = rd_rank;
                if (rd_parent != cur_reg) begin
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ufst_pkg::OP_COMP_A: begin
                if (cur_reg != root_a_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = {root_a_reg, rd_rank};
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ufst_pkg::OP_COMP_B: begin
                if (cur_reg != root_b_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = {root_b_reg, rd_rank};
                    cur_next  = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            ufst_pkg::OP_UNION: begin
                if (root_a_reg != root_b_reg) begin
                    ram_we      = 1'b1;
                    sum_next    = sum_reg + ufst_pkg::TOTAL_W'(weight_reg);
                    joined_next = 1'b1;
                    if (rank_a_reg > rank_b_reg) begin
                        ram_waddr = root_b_reg;
                        ram_wdata = {root_a_reg, rank_b_reg};
                    end else begin
                        ram_waddr = root_a_reg;
                        ram_wdata = {root_b_reg, rank_a_reg};
                    end
                end
            end
            ufst_pkg::OP_RANK_UP: begin
                // tie: second root gains a rank, saturating
                if (rank_a_reg == rank_b_reg && rank_b_reg != ufst_pkg::RANK_MAX) begin
                    ram_we    = 1'b1;
                    ram_waddr = root_b_reg;
                    ram_wdata = {root_b_reg, rank_b_reg + 1'b1};
                end
            end
            default: begin
            end
        endcase

        if (op == ufst_pkg::OP_EMIT && !out_busy) begin
            m_valid_next  = 1'b1;
            m_joined_next = joined_reg;
            m_bad_next    = bad_reg;
            m_total_next  = sum_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            node_count_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= ufst_pkg::NODE_COUNT_RST;
            item_reg       <= 1'b0;
            sum_reg        <= '0;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            node_count_reg <= node_count_next;
            item_reg       <= item_next;
            sum_reg        <= sum_next;
            clr_cnt_reg    <= clr_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        weight_reg   <= weight_next;
        bad_reg      <= bad_next;
        joined_reg   <= joined_next;
        cur_reg      <= cur_next;
        root_a_reg   <= root_a_next;
        root_b_reg   <= root_b_next;
        rank_a_reg   <= rank_a_next;
        rank_b_reg   <= rank_b_next;
        m_joined_reg <= m_joined_next;
        m_bad_reg    <= m_bad_next;
        m_total_reg  <= m_total_next;
    end

endmodule

>>> rtl/union_find_spanning_tree_weight.sv
// union_find_spanning_tree_weight: top level, microcoded sequencer driving the datapath
// depends on ufst_pkg, ufst_seq and ufst_dp (which holds the ufst_ram node store)
// each edge chases the roots of a and b through the node store, one store read per hop
// out-of-range edge: flagged and sent to its result with no search; clear request: sweeps the whole store
// one request in flight; the next is taken while a finished result waits on the output
// after reset a clearing pass over the whole node store runs before the first request is taken
module union_find_spanning_tree_weight #(
    parameter int MAX_NODES = ufst_pkg::MAX_NODES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ufst_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [ufst_pkg::NODE_W-1:0]   s_node_a,
    input  logic [ufst_pkg::NODE_W-1:0]   s_node_b,
    input  logic [ufst_pkg::WEIGHT_W-1:0] s_edge_weight,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_joined,
    output logic [ufst_pkg::TOTAL_W-1:0]  m_total_weight,
    output logic                          m_bad_node
);

    ufst_pkg::uop_t   op;
    ufst_pkg::flags_t flags;

    ufst_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    ufst_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .flags          (flags),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .s_edge_weight  (s_edge_weight),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_joined       (m_joined),
        .m_total_weight (m_total_weight),
        .m_bad_node     (m_bad_node)
    );

endmodule

>>> rtl/ufst_checker.sv
// ufst_checker: port-level assertions for the union-find edge stage, bound to the top level
// depends on ufst_pkg and union_find_spanning_tree_weight
module ufst_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_joined,
    input logic [ufst_pkg::TOTAL_W-1:0] m_total_weight,
    input logic                         m_bad_node
);

    // reset starts the clearing pass: no request taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid right after reset");

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken back to back");

    // a flagged edge never joins
    a_bad_not_joined: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_joined && m_bad_node))
        else $error("result both joined and flagged");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_weight)
            && $stable(m_joined) && $stable(m_bad_node))
        else $error("stalled result changed");

endmodule

bind union_find_spanning_tree_weight ufst_checker u_ufst_checker (.*);

>>> test/tb_top.sv
// tb_top: self-checking bench for union_find_spanning_tree_weight, a directed table then
// random edge streams over several node counts, with a union-find predictor for the results
// depends on ufst_pkg and the rtl top level only
module tb_top;

    localparam int NODES = ufst_pkg::MAX_NODES_DEF;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 17;

    typedef struct packed {
        logic                          joined;
        logic [ufst_pkg::TOTAL_W-1:0]  total;
        logic                          bad;
    } edge_outcome_t;

    typedef struct packed {
        logic [ufst_pkg::COUNT_W-1:0]  nc;
        logic                          kind;
        logic [ufst_pkg::NODE_W-1:0]   a;
        logic [ufst_pkg::NODE_W-1:0]   b;
        logic [ufst_pkg::WEIGHT_W-1:0] w;
        logic                          typed;
        edge_outcome_t                 outcome;
    } stim_row_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          cfg_wr_en     = 1'b0;
    logic [ufst_pkg::COUNT_W-1:0]  cfg_wr_data   = '0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic                          s_kind        = 1'b0;
    logic [ufst_pkg::NODE_W-1:0]   s_node_a      = '0;
    logic [ufst_pkg::NODE_W-1:0]   s_node_b      = '0;
    logic [ufst_pkg::WEIGHT_W-1:0] s_edge_weight = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic                          m_joined;
    logic [ufst_pkg::TOTAL_W-1:0]  m_total_weight;
    logic                          m_bad_node;

    // predictor state
    logic [ufst_pkg::NODE_W-1:0]   uf_parent [NODES];
    logic [ufst_pkg::RANK_W-1:0]   uf_rank [NODES];
    logic [ufst_pkg::TOTAL_W-1:0]  span_total;
    logic [ufst_pkg::COUNT_W-1:0]  node_limit;

    edge_outcome_t edge_outcomes [$];
    stim_row_t     dir_rows [25];
    logic [ufst_pkg::COUNT_W-1:0]  phase_nc [13];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  quiet          = 1'b0;

    union_find_spanning_tree_weight u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .s_edge_weight  (s_edge_weight),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_joined       (m_joined),
        .m_total_weight (m_total_weight),
        .m_bad_node     (m_bad_node)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_store();
        for (int i = 0; i < NODES; i++) begin
            uf_parent[i] = ufst_pkg::NODE_W'(i);
            uf_rank[i]   = '0;
        end
        span_total = '0;
    endfunction

    function automatic logic [ufst_pkg::NODE_W-1:0] root_with_compress(
        input logic [ufst_pkg::NODE_W-1:0] x
    );
        logic [ufst_pkg::NODE_W-1:0] root;
        logic [ufst_pkg::NODE_W-1:0] cur;
        logic [ufst_pkg::NODE_W-1:0] nxt;
        int steps;
        root  = x;
        steps = 0;
        while (uf_parent[root] != root && steps < NODES) begin
            root = uf_parent[root];
            steps++;
        end
        cur   = x;
        steps = 0;
        while (cur != root && steps < NODES) begin
            nxt            = uf_parent[cur];
            uf_parent[cur] = root;
            cur            = nxt;
            steps++;
        end
        return root;
    endfunction

    function automatic edge_outcome_t kruskal_step(
        input logic                          kind,
        input logic [ufst_pkg::NODE_W-1:0]   a,
        input logic [ufst_pkg::NODE_W-1:0]   b,
        input logic [ufst_pkg::WEIGHT_W-1:0] w
    );
        edge_outcome_t r;
        int limit;
        logic [ufst_pkg::NODE_W-1:0] ra;
        logic [ufst_pkg::NODE_W-1:0] rb;
        r     = '0;
        limit = (int'(node_limit) > NODES) ? NODES : int'(node_limit);
        if (kind == KIND_CLEAR) begin
            clear_store();
        end else if (int'(a) >= limit || int'(b) >= limit) begin
            r.bad = 1'b1;
        end else begin
            ra = root_with_compress(a);
            rb = root_with_compress(b);
            if (ra != rb) begin
                span_total = span_total + ufst_pkg::TOTAL_W'(w);
                r.joined   = 1'b1;
                if (uf_rank[ra] < uf_rank[rb]) begin
                    uf_parent[ra] = rb;
                end else if (uf_rank[ra] > uf_rank[rb]) begin
                    uf_parent[rb] = ra;
                end else begin
                    uf_parent[ra] = rb;
                    if (uf_rank[rb] < ufst_pkg::RANK_MAX) begin
                        uf_rank[rb] = uf_rank[rb] + 1'b1;
                    end
                end
            end
        end
        r.total = span_total;
        return r;
    endfunction

    // offer one request, hold it until taken, then record what it should produce
    task automatic push_request(
        input logic                          kind,
        input logic [ufst_pkg::NODE_W-1:0]   a,
        input logic [ufst_pkg::NODE_W-1:0]   b,
        input logic [ufst_pkg::WEIGHT_W-1:0] w,
        input logic                          typed,
        input edge_outcome_t                 typed_outcome
    );
        int gap;
        edge_outcome_t predicted;
        edge_outcome_t queued;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_node_a      <= a;
        s_node_b      <= b;
        s_edge_weight <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = kruskal_step(kind, a, b, w);
        queued    = typed ? typed_outcome : predicted;
        edge_outcomes = {edge_outcomes, queued};
    endtask

    task automatic set_node_count(input logic [ufst_pkg::COUNT_W-1:0] value);
        s_valid <= 1'b0;
        while (edge_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        node_limit = value;
    endtask

    // result side: compare, then pick the next ready
    always @(posedge aclk) begin
        edge_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (edge_outcomes.size() == 0) begin
                $error("result with no request pending: joined %0d total %0d bad_node %0d",
                       m_joined, m_total_weight, m_bad_node);
                mismatch_count++;
            end else begin
                want = edge_outcomes.pop_front();
                if (m_joined !== want.joined) begin
                    $error("joined: expected %0d, actual %0d", want.joined, m_joined);
                    mismatch_count++;
                end
                if (m_total_weight !== want.total) begin
                    $error("total_weight: expected %0d, actual %0d", want.total,
                           m_total_weight);
                    mismatch_count++;
                end
                if (m_bad_node !== want.bad) begin
                    $error("bad_node: expected %0d, actual %0d", want.bad, m_bad_node);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int limit;
        int n_items;
        int pick;
        int wcur;
        logic                          kind;
        logic [ufst_pkg::NODE_W-1:0]   a;
        logic [ufst_pkg::NODE_W-1:0]   b;
        logic [ufst_pkg::WEIGHT_W-1:0] w;

        clear_store();
        node_limit = ufst_pkg::NODE_COUNT_RST;

        dir_rows = '{
            '{9'd256, KIND_EDGE,  8'd0,   8'd0,   16'd100,   1'b1, '{1'b0, 32'd0,      1'b0}},
            '{9'd256, KIND_EDGE,  8'd0,   8'd255, 16'd65535, 1'b1, '{1'b1, 32'd65535,  1'b0}},
            '{9'd256, KIND_EDGE,  8'd255, 8'd0,   16'd7,     1'b1, '{1'b0, 32'd65535,  1'b0}},
            '{9'd256, KIND_EDGE,  8'd1,   8'd2,   16'd0,     1'b1, '{1'b1, 32'd65535,  1'b0}},
            '{9'd256, KIND_EDGE,  8'd3,   8'd4,   16'd1,     1'b1, '{1'b1, 32'd65536,  1'b0}},
            '{9'd256, KIND_EDGE,  8'd1,   8'd3,   16'd2,     1'b0, '0},
            '{9'd256, KIND_EDGE,  8'd0,   8'd1,   16'd5,     1'b0, '0},
            '{9'd256, KIND_EDGE,  8'd5,   8'd6,   16'd65535, 1'b0, '0},
            '{9'd256, KIND_EDGE,  8'd0,   8'd6,   16'd9,     1'b0, '0},
            '{9'd256, KIND_CLEAR, 8'd255, 8'd255, 16'd65535, 1'b1, '{1'b0, 32'd0,      1'b0}},
            '{9'd256, KIND_EDGE,  8'd0,   8'd1,   16'd9,     1'b1, '{1'b1, 32'd9,      1'b0}},
            '{9'd10,  KIND_EDGE,  8'd10,  8'd0,   16'd5,     1'b1, '{1'b0, 32'd9,      1'b1}},
            '{9'd10,  KIND_EDGE,  8'd0,   8'd255, 16'd65535, 1'b1, '{1'b0, 32'd9,      1'b1}},
            '{9'd10,  KIND_EDGE,  8'd9,   8'd8,   16'd3,     1'b1, '{1'b1, 32'd12,     1'b0}},
            '{9'd10,  KIND_EDGE,  8'd1,   8'd0,   16'd4,     1'b1, '{1'b0, 32'd12,     1'b0}},
            '{9'd1,   KIND_EDGE,  8'd0,   8'd0,   16'd1,     1'b1, '{1'b0, 32'd12,     1'b0}},
            '{9'd1,   KIND_EDGE,  8'd0,   8'd1,   16'd1,     1'b1, '{1'b0, 32'd12,     1'b1}},
            '{9'd1,   KIND_EDGE,  8'd1,   8'd0,   16'd2,     1'b1, '{1'b0, 32'd12,     1'b1}},
            '{9'd0,   KIND_EDGE,  8'd0,   8'd0,   16'd0,     1'b1, '{1'b0, 32'd12,     1'b1}},
            '{9'd0,   KIND_CLEAR, 8'd0,   8'd0,   16'd0,     1'b1, '{1'b0, 32'd0,      1'b0}},
            '{9'd511, KIND_EDGE,  8'd255, 8'd254, 16'd65535, 1'b1, '{1'b1, 32'd65535,  1'b0}},
            '{9'd511, KIND_EDGE,  8'd254, 8'd255, 16'd1,     1'b1, '{1'b0, 32'd65535,  1'b0}},
            '{9'd300, KIND_EDGE,  8'd255, 8'd0,   16'd65535, 1'b1, '{1'b1, 32'd131070, 1'b0}},
            '{9'd256, KIND_EDGE,  8'd128, 8'd127, 16'd32768, 1'b0, '0},
            '{9'd256, KIND_EDGE,  8'd0,   8'd127, 16'd40000, 1'b0, '0}
        };

        phase_nc = '{9'd16, 9'd256, 9'd2, 9'd64, 9'd511, 9'd1, 9'd200,
                     9'd8, 9'd0, 9'd128, 9'd300, 9'd37, 9'd256};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_node_count(ufst_pkg::NODE_COUNT_RST);

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].nc != node_limit) set_node_count(dir_rows[r].nc);
            push_request(dir_rows[r].kind, dir_rows[r].a, dir_rows[r].b, dir_rows[r].w,
                         dir_rows[r].typed, dir_rows[r].outcome);
        end

        // random edge streams, mostly in range with rising weights
        wcur = 0;
        foreach (phase_nc[p]) begin
            set_node_count(phase_nc[p]);
            quiet   = (p == 4);
            limit   = (int'(node_limit) > NODES) ? NODES : int'(node_limit);
            n_items = (limit <= 1) ? 30 : $urandom_range(140, 170);
            for (int i = 0; i < n_items; i++) begin
                pick = $urandom_range(0, 99);
                kind = KIND_EDGE;
                a    = ufst_pkg::NODE_W'($urandom);
                b    = ufst_pkg::NODE_W'($urandom);
                w    = ufst_pkg::WEIGHT_W'($urandom);
                if (pick < 2) begin
                    kind = KIND_CLEAR;
                    wcur = 0;
                end else begin
                    if (pick >= 10 && limit > 0) begin
                        a = ufst_pkg::NODE_W'($urandom_range(0, limit - 1));
                        b = ufst_pkg::NODE_W'($urandom_range(0, limit - 1));
                    end else if (limit > 0 && limit < NODES) begin
                        if ($urandom_range(0, 1) == 1) begin
                            a = ufst_pkg::NODE_W'($urandom_range(limit, NODES - 1));
                        end else begin
                            b = ufst_pkg::NODE_W'($urandom_range(limit, NODES - 1));
                        end
                    end
                    if ($urandom_range(0, 19) != 0) begin
                        wcur = wcur + $urandom_range(0, 40);
                        if (wcur > 65535) wcur = 65535;
                        w = ufst_pkg::WEIGHT_W'(wcur);
                    end
                end
                push_request(kind, a, b, w, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        while (edge_outcomes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
